// File: rtl/fwbh_pkg.sv
// Package for the four-word blob identifier hash.
// Holds the lane seeds, the finalization constants and the lane mixing functions.
// Has no dependencies.
`default_nettype none
package fwbh_pkg;

	localparam int LANE_COUNT     = 4;
	localparam int LENGTH_BITS_DEF = 32;
	localparam int LENGTH_FIELD   = 32;
	localparam int DATA_BITS      = 40;
	localparam int WORD_BITS      = 64;
	localparam int MIX_SHIFT      = 29;

	localparam logic [63:0] GOLDEN_RATIO = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] ZERO_FIX     = 64'h0100_0000_0000_0000;

	localparam logic [63:0] LANE_SEED [LANE_COUNT] = '{
		64'd1469598103934665603,
		64'd1099511628211,
		64'd7809847782465536322,
		64'd9650029242287828579
	};

	localparam logic [63:0] LANE_FINAL [LANE_COUNT] = '{
		64'(GOLDEN_RATIO * 64'd1),
		64'(GOLDEN_RATIO * 64'd2),
		64'(GOLDEN_RATIO * 64'd3),
		64'(GOLDEN_RATIO * 64'd4)
	};

	// prime is 2^40 + 0x1b3; 0x1b3 = bits 8,7,5,4,1,0
	function automatic logic [63:0] fnv_mul(input logic [63:0] h);
		return h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
	endfunction

	function automatic logic [63:0] lane_mix(
		input logic [63:0] h,
		input logic [7:0]  tag,
		input logic [7:0]  data
	);
		logic [63:0] x;
		logic [63:0] p;
		x = h ^ {48'd0, tag, data};
		p = fnv_mul(x);
		return p ^ (p >> MIX_SHIFT);
	endfunction

endpackage
`default_nettype wire

// File: rtl/four_word_blob_id_hash.sv
// Four-word blob identifier hash: four 64-bit FNV-1a style lanes over a byte stream.
// The identifier is registered and valid in the cycle after the final request is accepted.
// Throughput: one request per cycle while s_tready is high; the lane update is one shifted-add multiply per lane.
// s_tready drops only for a final request while an earlier identifier is still unaccepted.
// Reset (arst_n low, asynchronous) clears the lanes, the message flag and the output valid.
// Depends on fwbh_pkg.
`default_nettype none
module four_word_blob_id_hash
	import fwbh_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [DATA_BITS-1:0]   s_tdata,   // data_byte[7:0], message_length[39:8]
	input  wire logic                   s_tuser,   // has_data
	input  wire logic                   s_tlast,   // last_item
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [4*WORD_BITS-1:0]      m_tdata    // id_word0, id_word1, id_word2, id_word3
);

	localparam int USED_BITS = (LENGTH_BITS < LENGTH_FIELD) ? LENGTH_BITS : LENGTH_FIELD;

	logic [63:0] lane_hash_q [LANE_COUNT];
	logic        in_message_q;
	logic [63:0] lane_next  [LANE_COUNT];
	logic [63:0] lane_final [LANE_COUNT];
	logic [63:0] len64;
	logic [7:0]  data_byte;
	logic        accept;
	logic        any_set;
	logic [4*WORD_BITS-1:0] result;

	assign data_byte = s_tdata[7:0];
	assign len64     = {{(64-USED_BITS){1'b0}}, s_tdata[8 +: USED_BITS]};
	assign s_tready  = !m_tvalid || m_tready || !s_tlast;
	assign accept    = s_tvalid && s_tready;

	for (genvar w = 0; w < LANE_COUNT; w++) begin : g_lane
		logic [63:0] seeded;
		assign seeded = in_message_q ? lane_hash_q[w] : (LANE_SEED[w] ^ len64);
		assign lane_next[w]  = s_tuser ? lane_mix(seeded, 8'(w + 1), data_byte) : seeded;
		assign lane_final[w] = lane_next[w] ^ LANE_FINAL[w];
	end

	always_comb begin
		any_set = |{lane_final[0], lane_final[1], lane_final[2], lane_final[3]};
		result  = {any_set ? lane_final[3] : ZERO_FIX, lane_final[2], lane_final[1],
			lane_final[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			for (int w = 0; w < LANE_COUNT; w++) begin
				lane_hash_q[w] <= '0;
			end
		end else if (accept) begin
			in_message_q <= !s_tlast;
			for (int w = 0; w < LANE_COUNT; w++) begin
				lane_hash_q[w] <= lane_next[w];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept && s_tlast) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			m_tdata <= result;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && accept) |-> !s_tlast)
		else $error("final request accepted over a held identifier");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(accept && s_tlast))
		else $error("identifier valid without a final request");

	a_msg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (in_message_q == !$past(s_tlast)))
		else $error("message flag out of step with requests");

	a_nonzero_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != '0))
		else $error("all-zero identifier emitted");

endmodule
`default_nettype wire

// File: dv/four_word_blob_id_hash_tb.sv
// Testbench for four_word_blob_id_hash: byte messages in, 256-bit identifiers out.
// Predicts each identifier from its own four-lane hash model and checks every word in order.
// Depends on fwbh_pkg and the four_word_blob_id_hash RTL.
`default_nettype none
module four_word_blob_id_hash_tb;
	import fwbh_pkg::*;

	localparam logic [63:0] FNV_PRIME_64 = 64'd1099511628211;
	localparam logic [63:0] PHI_STEP     = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] ZERO_ID_MARK = 64'h0100_0000_0000_0000;
	localparam int          MIX_RSHIFT   = 29;
	localparam logic [63:0] LANE_INIT [4] = '{
		64'd1469598103934665603,
		64'd1099511628211,
		64'd7809847782465536322,
		64'd9650029242287828579
	};
	localparam int RANDOM_ITEMS = 1850;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [DATA_BITS-1:0]    s_tdata;   // data_byte[7:0], message_length[39:8]
	logic                    s_tuser;   // has_data
	logic                    s_tlast;   // last_item
	logic                    m_tvalid;
	logic                    m_tready;
	logic [4*WORD_BITS-1:0]  m_tdata;   // id_word0, id_word1, id_word2, id_word3

	logic [63:0]  lane_acc [4];
	logic         in_msg;
	logic [255:0] pending_ids [$];
	int           fail_count;
	int           items_sent;
	int           tx_gap_pct;
	int           rx_stall_pct;
	int           rx_hold_req;

	four_word_blob_id_hash u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int gap_len(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	task automatic absorb_request(
		input logic [7:0]  b,
		input logic        has,
		input logic [31:0] len,
		input logic        last
	);
		logic [63:0]  h;
		logic [63:0]  any;
		logic [255:0] id;
		if (!in_msg) begin
			for (int w = 0; w < 4; w++)
				lane_acc[w] = LANE_INIT[w] ^ {32'd0, len};
		end
		if (has) begin
			for (int w = 0; w < 4; w++) begin
				h = lane_acc[w] ^ ({56'd0, b} + (64'(w + 1) << 8));
				h = h * FNV_PRIME_64;
				h = h ^ (h >> MIX_RSHIFT);
				lane_acc[w] = h;
			end
		end
		if (!last) begin
			in_msg = 1'b1;
			return;
		end
		any = '0;
		for (int w = 0; w < 4; w++) begin
			id[64*w +: 64] = lane_acc[w] ^ (64'(w + 1) * PHI_STEP);
			any |= id[64*w +: 64];
		end
		if (any == '0)
			id[255:192] = ZERO_ID_MARK;
		pending_ids = {pending_ids, id};
		in_msg = 1'b0;
	endtask

	task automatic send_item(
		input logic [7:0]  b,
		input logic        has,
		input logic [31:0] len,
		input logic        last
	);
		int gap;
		gap = gap_len(tx_gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {len, b};
		s_tuser  <= has;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		absorb_request(b, has, len, last);
		items_sent++;
	endtask

	task automatic send_message(input int n);
		logic [31:0] declared;
		logic        first;
		logic        tail_empty;
		int          r;
		r = $urandom_range(99);
		if (r < 70)
			declared = n;
		else if (r < 90)
			declared = $urandom;
		else if (r < 95)
			declared = '0;
		else
			declared = '1;
		tail_empty = ($urandom_range(6) == 0);
		first = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom), 1'b0, first ? declared : $urandom, 1'b0);
				first = 1'b0;
			end
			send_item(8'($urandom), 1'b1, first ? declared : $urandom,
				(i == n - 1) && !tail_empty);
			first = 1'b0;
		end
		if (tail_empty)
			send_item(8'($urandom), 1'b0, $urandom, 1'b1);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_ids.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		send_item(8'h00, 1'b0, 32'h0000_0000, 1'b1);
		send_item(8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b1);
		send_item(8'h00, 1'b1, 32'h0000_0001, 1'b1);
		send_item(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// no-data item mid-message and a new length that must be ignored
		send_item(8'h5A, 1'b1, 32'h0000_0003, 1'b0);
		send_item(8'h00, 1'b0, 32'hDEAD_BEEF, 1'b0);
		send_item(8'hA5, 1'b1, 32'h0000_0000, 1'b0);
		send_item(8'h01, 1'b1, 32'h0000_0007, 1'b1);
		// close with a no-data last item
		send_item(8'h80, 1'b1, 32'h0000_0002, 1'b0);
		send_item(8'h7F, 1'b1, 32'h0000_0002, 1'b0);
		send_item(8'hC7, 1'b0, 32'h0000_0002, 1'b1);
		// declared length disagrees with byte count
		send_item(8'h33, 1'b1, 32'd100, 1'b1);
		send_item(8'hC3, 1'b1, 32'd0, 1'b0);
		send_item(8'h3C, 1'b1, 32'd0, 1'b1);
		tx_gap_pct   = 50;
		rx_stall_pct = 50;
		send_item(8'h55, 1'b1, 32'h8000_0000, 1'b1);
		send_item(8'hAA, 1'b0, 32'h5555_5555, 1'b1);
		send_item(8'h0F, 1'b1, 32'hAAAA_AAAA, 1'b1);
		send_item(8'hF0, 1'b1, 32'h0000_FFFF, 1'b1);
	endtask

	task automatic test_random();
		int stop_at;
		int r;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(15) == 0) begin
				case ($urandom_range(3))
					0: tx_gap_pct = 0;
					1: tx_gap_pct = 10;
					2: tx_gap_pct = 30;
					default: tx_gap_pct = 60;
				endcase
				case ($urandom_range(3))
					0: rx_stall_pct = 0;
					1: rx_stall_pct = 10;
					2: rx_stall_pct = 30;
					default: rx_stall_pct = 60;
				endcase
			end
			r = $urandom_range(99);
			if (r < 8)
				send_item(8'($urandom), 1'b0, $urandom, 1'b1);
			else if (r < 12)
				send_item(8'($urandom), 1'($urandom), $urandom, 1'($urandom));
			else if ($urandom_range(9) == 0)
				send_message($urandom_range(120, 25));
			else
				send_message($urandom_range(12, 1));
		end
	endtask

	task automatic test_backpressure();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 300;
		while (m_tready) @(posedge clk);
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 0)
				send_item(8'($urandom), 1'b0, $urandom, 1'b1);
			else
				send_message($urandom_range(3, 1));
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				stall_left  = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = gap_len(rx_stall_pct);
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin : check_ids
		logic [255:0] want;
		if (m_tvalid && m_tready) begin
			if (pending_ids.size() == 0) begin
				$error("unexpected identifier %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_ids.pop_front();
				for (int w = 0; w < 4; w++) begin
					if (m_tdata[64*w +: 64] !== want[64*w +: 64]) begin
						$error("id_word%0d expected %h actual %h", w,
							want[64*w +: 64], m_tdata[64*w +: 64]);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		s_tlast      = 1'b0;
		in_msg       = 1'b0;
		fail_count   = 0;
		items_sent   = 0;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 0;
		for (int w = 0; w < 4; w++)
			lane_acc[w] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drain();
		test_random();
		wait_drain();
		test_backpressure();
		wait_drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
